// File: design/ccs_pkg.sv
`timescale 1ns / 1ps
package ccs_pkg;
	// sums hold MaxHits full-charge hits before they saturate
	localparam int MaxHits = 1024;
	localparam int QsumW = $clog2(MaxHits) + 16;
	localparam int WsumW = QsumW + 16;
	localparam int ScoreW = 24;
	localparam int WquoW = 17;          // weight quotient, up to 1.0 in Q0.16
	localparam int FquoW = ScoreW + 1;  // score quotient plus an overflow bit
	localparam logic [1:0] REG_CONE_EDGE = 2'd0;
	localparam logic [1:0] REG_INNER = 2'd1;
	localparam logic [1:0] REG_OUTER = 2'd2;
	localparam logic [1:0] REG_BASE = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture hit, start weight division
		logic div_step;   // one quotient bit
		logic accum;      // add weighted charge into sums
		logic fin_start;  // start final division
		logic fin_step;
		logic clear;      // clear sums, latch result
	} ccs_cmd_t;
endpackage

// File: design/ccs_datapath.sv
`timescale 1ns / 1ps
module ccs_datapath
	import ccs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ccs_cmd_t            cmd,
	input  logic [16:0]         hit_angle,
	input  logic [15:0]         hit_charge,
	input  logic                counted,
	input  logic [15:0]         cone_edge,
	input  logic [14:0]         inner_width,
	input  logic [14:0]         outer_width,
	input  logic [15:0]         base_score,
	output logic [ScoreW-1:0]   score,
	output logic                no_charge
);
	localparam logic [16:0] InnerFloor = 17'd49152;  // 0.75 in Q0.16

	// weight division: dividend w^2*scale + den/2 is 47 bits, den is 35 bits
	logic [15:0] charge_q;
	logic        count_q;
	logic        inside_q;
	logic [34:0] den_q;
	logic [34:0] rem_q;
	logic [WquoW-1:0] quo_q;  // dividend bits shift out on top, quotient bits in below
	logic [WsumW-1:0] wsum_q;
	logic [QsumW-1:0] qsum_q;
	logic [QsumW+7:0] frem_q;
	logic [FquoW-1:0] fquo_q;

	logic signed [17:0] d;
	logic [16:0] absd;
	logic [14:0] w;
	logic [29:0] w2;
	logic [33:0] d2;
	logic [34:0] den;
	logic [46:0] wdvd;
	logic [35:0] trial;
	logic [16:0] weight;
	logic [32:0] prod;
	logic [WsumW:0] wsum_n;
	logic [QsumW:0] qsum_n;
	logic [QsumW+7:0] fden;
	logic [WsumW+15:0] fprod;
	logic [WsumW+16:0] fdvd;
	logic [QsumW+8:0] ftrial;

	always_comb begin
		d = $signed({hit_angle[16], hit_angle}) - $signed({2'b00, cone_edge});
		absd = (d <= 0) ? 17'(-d) : 17'(d);
		w = (d <= 0) ? inner_width : outer_width;
		if (w == '0) w = 15'd1;
		w2 = w * w;
		d2 = absd * absd;
		den = 35'(w2) + 35'(d2);
		// scale is 2^14 inside the cone, 2^16 outside
		wdvd = (d <= 0) ? {3'd0, w2, 14'd0} : {1'b0, w2, 16'd0};
		wdvd = wdvd + 47'(den >> 1);
		trial = {rem_q, quo_q[WquoW-1]};
		weight = inside_q ? 17'(InnerFloor + quo_q) : quo_q;
		prod = charge_q * weight;
		wsum_n = {1'b0, wsum_q} + (WsumW+1)'(prod);
		qsum_n = {1'b0, qsum_q} + (QsumW+1)'(charge_q);
		// score = (base*wsum + den/2) / den, den = qsum*256
		fden = {qsum_q, 8'd0};
		fprod = base_score * wsum_q;
		fdvd = {1'b0, fprod} + (WsumW+17)'({qsum_q, 7'd0});
		ftrial = {frem_q, fquo_q[FquoW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
			count_q <= 1'b0;
			inside_q <= 1'b0;
			den_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			wsum_q <= '0;
			qsum_q <= '0;
			frem_q <= '0;
			fquo_q <= '0;
			score <= '0;
			no_charge <= 1'b0;
		end else begin
			if (cmd.load) begin
				charge_q <= hit_charge;
				count_q <= counted;
				inside_q <= (d <= 0);
				den_q <= den;
				// quotient fits in WquoW bits, so the top bits start below den
				rem_q <= 35'(wdvd[46:WquoW]);
				quo_q <= wdvd[WquoW-1:0];
			end else if (cmd.div_step) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= 35'(trial - {1'b0, den_q});
					quo_q <= {quo_q[WquoW-2:0], 1'b1};
				end else begin
					rem_q <= trial[34:0];
					quo_q <= {quo_q[WquoW-2:0], 1'b0};
				end
			end
			if (cmd.clear) begin
				wsum_q <= '0;
				qsum_q <= '0;
			end else if (cmd.accum && count_q) begin
				wsum_q <= wsum_n[WsumW] ? '1 : wsum_n[WsumW-1:0];
				qsum_q <= qsum_n[QsumW] ? '1 : qsum_n[QsumW-1:0];
			end
			if (cmd.fin_start) begin
				frem_q <= fdvd[WsumW+16:FquoW];
				fquo_q <= fdvd[FquoW-1:0];
			end else if (cmd.fin_step) begin
				if (ftrial >= {1'b0, fden}) begin
					frem_q <= (QsumW+8)'(ftrial - {1'b0, fden});
					fquo_q <= {fquo_q[FquoW-2:0], 1'b1};
				end else begin
					frem_q <= ftrial[QsumW+7:0];
					fquo_q <= {fquo_q[FquoW-2:0], 1'b0};
				end
			end
			if (cmd.clear) begin
				no_charge <= (qsum_q == '0);
				score <= (qsum_q == '0) ? '0 :
					((fquo_q[FquoW-1:ScoreW] != '0) ? '1 : fquo_q[ScoreW-1:0]);
			end
		end
	end
endmodule

// File: design/ccs_ctrl.sv
`timescale 1ns / 1ps
module ccs_ctrl
	import ccs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     in_last,
	input  logic     out_taken,
	output logic     in_ready,
	output logic     out_valid,
	output ccs_cmd_t cmd
);
	typedef enum logic [2:0] {IDLE, WDIV, ACC, FLOAD, FDIV, DONE} state_t;
	state_t state_q;
	logic [4:0] cnt_q;
	logic last_q;
	logic res_free;

	always_comb begin
		// output register can take a new result this cycle
		res_free = !out_valid || out_taken;
		cmd = '0;
		cmd.load = in_fire;
		cmd.div_step = (state_q == WDIV);
		cmd.accum = (state_q == ACC);
		cmd.fin_start = (state_q == FLOAD);
		cmd.fin_step = (state_q == FDIV);
		cmd.clear = (state_q == DONE) && res_free;
		in_ready = (state_q == IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			last_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear) out_valid <= 1'b1;
			else if (out_taken) out_valid <= 1'b0;
			case (state_q)
				IDLE: if (in_fire) begin
					state_q <= WDIV;
					cnt_q <= 5'(WquoW - 1);
					last_q <= in_last;
				end
				WDIV: begin
					if (cnt_q == 5'd0) state_q <= ACC;
					else cnt_q <= cnt_q - 5'd1;
				end
				ACC: begin
					state_q <= last_q ? FLOAD : IDLE;
				end
				FLOAD: begin
					state_q <= FDIV;
					cnt_q <= 5'(FquoW - 1);
				end
				FDIV: begin
					if (cnt_q == 5'd0) state_q <= DONE;
					else cnt_q <= cnt_q - 5'd1;
				end
				DONE: begin
					if (res_free) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// File: design/cone_charge_score.sv
`timescale 1ns / 1ps
// Hits: one hit is taken at a time (load, 17-step weight divider, accumulate, idle).
// An end-of-event hit holds the input until its result is latched; its result beat is valid
// once the added 25-step score divider and the result latch are done.
// A result still waiting on m_tready stalls the next event's result and the input with it.
// Reset: arst_n asynchronous active low; registers go to defaults,
// sums clear after each event result.
module cone_charge_score
	import ccs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // hit_angle[16:0], hit_charge[32:17], zero fill
	input  logic [1:0]  s_tuser,  // hit_selected, is_tube_hit
	input  logic        s_tlast,  // end_of_event
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // score
	output logic        m_tuser,  // no_charge
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	logic [15:0] cone_edge_q, base_q;
	logic [14:0] inner_q, outer_q;
	ccs_cmd_t cmd;
	logic in_fire;

	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cone_edge_q <= 16'd10752;
			inner_q <= 15'd5376;
			outer_q <= 15'd768;
			base_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CONE_EDGE: cone_edge_q <= cfg_wdata;
				REG_INNER:     inner_q <= cfg_wdata[14:0];
				REG_OUTER:     outer_q <= cfg_wdata[14:0];
				REG_BASE:      base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ccs_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_last(s_tlast),
		.out_taken(m_tvalid && m_tready), .in_ready(s_tready),
		.out_valid(m_tvalid), .cmd
	);

	ccs_datapath u_dp (
		.clk, .arst_n, .cmd, .hit_angle(s_tdata[16:0]), .hit_charge(s_tdata[32:17]),
		.counted(s_tuser[0] && s_tuser[1]),
		.cone_edge(cone_edge_q), .inner_width(inner_q), .outer_width(outer_q),
		.base_score(base_q), .score(m_tdata), .no_charge(m_tuser)
	);
endmodule

// File: design/ccs_checker.sv
`timescale 1ns / 1ps
module ccs_assert (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [23:0] m_tdata,
	input logic m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("out held");
	a_nc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'd0) else $error("no_charge score");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready after beat");
endmodule

bind cone_charge_score ccs_assert u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tuser
);

// File: verif/ccs_checker.sv
`timescale 1ns / 1ps
module ccs_checker
	import ccs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,    // hit_angle[16:0], hit_charge[32:17], zero fill
	input  logic [1:0]  s_tuser,    // hit_selected, is_tube_hit
	input  logic        s_tlast,    // end_of_event
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,    // score
	input  logic        m_tuser,    // no_charge
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [ScoreW-1:0] score;
		logic              no_charge;
	} score_t;

	localparam longint unsigned WSUM_SAT = (64'd1 << WsumW) - 1;
	localparam longint unsigned QSUM_SAT = (64'd1 << QsumW) - 1;

	score_t score_q[$];
	logic [15:0] edge_r;
	logic [14:0] inner_r, outer_r;
	logic [15:0] base_r;
	longint unsigned wsum, qsum;

	// rounded scale * w^2 / (w^2 + d^2); zero width acts as one
	function automatic longint unsigned falloff_weight(longint unsigned width,
			longint unsigned absd, longint unsigned scale);
		longint unsigned w2, den;
		w2 = (width == 0) ? 1 : width * width;
		den = w2 + absd * absd;
		return (w2 * scale + den / 2) / den;
	endfunction

	task automatic take_hit(logic signed [16:0] angle, logic [15:0] charge, logic counted,
			logic last);
		longint signed offs;
		longint unsigned wt, num, den, s;
		score_t res;
		if (counted) begin
			offs = longint'(angle) - longint'({1'b0, edge_r});
			if (offs <= 0)
				wt = 49152 + falloff_weight(inner_r, -offs, 16384);
			else
				wt = falloff_weight(outer_r, offs, 65536);
			wsum = wsum + charge * wt;
			if (wsum > WSUM_SAT) wsum = WSUM_SAT;
			qsum = qsum + charge;
			if (qsum > QSUM_SAT) qsum = QSUM_SAT;
		end
		if (last) begin
			if (qsum == 0) begin
				res.score = '0;
				res.no_charge = 1'b1;
			end else begin
				num = base_r * wsum;
				den = qsum * 256;
				s = (num + den / 2) / den;
				res.score = (s > 64'hFFFFFF) ? 24'hFFFFFF : s[23:0];
				res.no_charge = 1'b0;
			end
			score_q = {score_q, res};
			wsum = 0;
			qsum = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		score_t exp_r;
		if (!arst_n) begin
			edge_r = 16'd10752;
			inner_r = 15'd5376;
			outer_r = 15'd768;
			base_r = 16'd100;
			wsum = 0;
			qsum = 0;
			errors = 0;
			score_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_CONE_EDGE: edge_r = cfg_wdata;
					REG_INNER: inner_r = cfg_wdata[14:0];
					REG_OUTER: outer_r = cfg_wdata[14:0];
					REG_BASE: base_r = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_hit(s_tdata[16:0], s_tdata[32:17], s_tuser[0] & s_tuser[1], s_tlast);
			if (m_tvalid && m_tready) begin
				if (score_q.size() == 0) begin
					$display("%0t: unexpected score beat score=%0d no_charge=%0b",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					exp_r = score_q.pop_front();
					if (m_tdata !== exp_r.score) begin
						$display("%0t: score expected %0d actual %0d", $time,
							exp_r.score, m_tdata);
						errors++;
					end
					if (m_tuser !== exp_r.no_charge) begin
						$display("%0t: no_charge expected %0b actual %0b", $time,
							exp_r.no_charge, m_tuser);
						errors++;
					end
				end
			end
			pending = score_q.size();
		end
	end
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import ccs_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [15:0] cfg_wdata = '0;
	int          errors, pending;
	int          cycles = 0;
	int          burst_left = 0;
	int          rx_mode = 0;
	logic [15:0] cur_edge = 16'd10752;
	logic [14:0] cur_width = 15'd768;

	always #5 clk = ~clk;

	cone_charge_score uut (.*);

	ccs_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[cone_charge_score] ERROR");
			$finish;
		end
	end

	// receiver: mode switches between always ready, random and periodic
	always @(negedge clk) begin
		if (cycles % 256 == 0) rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (cycles % 5) != 0;
		endcase
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(logic [15:0] edge_v, logic [15:0] inner_v, logic [15:0] outer_v,
			logic [15:0] base_v);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_CONE_EDGE, edge_v);
		write_reg(REG_INNER, inner_v);
		write_reg(REG_OUTER, outer_v);
		write_reg(REG_BASE, base_v);
		cur_edge = edge_v;
		cur_width = (outer_v[14:0] > inner_v[14:0]) ? outer_v[14:0] : inner_v[14:0];
	endtask

	task automatic send_hit(logic signed [16:0] angle, logic [15:0] charge, logic sel,
			logic tube, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) begin
				@(negedge clk);
				s_tvalid = 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {7'b0, charge, angle};
		s_tuser = {tube, sel};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// angles mostly within a few widths of the cone edge
	function automatic logic signed [16:0] pick_angle();
		int span;
		if ($urandom_range(0, 3) == 0) return 17'($urandom());
		span = 4 * cur_width + 16;
		return 17'(int'(cur_edge) + $urandom_range(0, 2 * span) - span);
	endfunction

	task automatic rand_event(int nhits);
		logic sel, tube;
		for (int i = 0; i < nhits; i++) begin
			sel = ($urandom_range(0, 7) != 0);
			tube = ($urandom_range(0, 7) != 0);
			send_hit(pick_angle(), 16'($urandom()), sel, tube, i == nhits - 1);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, default registers
		send_hit(17'sd10752, 16'hFFFF, 1'b1, 1'b1, 1'b1);  // on the edge: full weight
		send_hit(17'sh10000, 16'h0001, 1'b1, 1'b1, 1'b0);  // most negative angle
		send_hit(17'sh0FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);  // most positive angle
		send_hit(17'sd0, 16'h1234, 1'b0, 1'b1, 1'b0);
		send_hit(17'sd0, 16'h1234, 1'b1, 1'b0, 1'b0);
		send_hit(17'sd20000, 16'h0100, 1'b0, 1'b0, 1'b1);  // uncounted last hit
		send_hit(17'sd500, 16'h0000, 1'b1, 1'b1, 1'b1);    // zero charge only
		send_hit(17'sd500, 16'h5555, 1'b0, 1'b1, 1'b0);
		send_hit(17'sd500, 16'h5555, 1'b1, 1'b0, 1'b1);    // nothing counted
		send_hit(17'sd10753, 16'h00FF, 1'b1, 1'b1, 1'b1);  // just outside
		// zero widths act as one; max base
		set_regs(16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_hit(17'sd0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_hit(17'sd1, 16'h8000, 1'b1, 1'b1, 1'b0);
		send_hit(-17'sd1, 16'h8000, 1'b1, 1'b1, 1'b1);
		// bit 15 of widths is dropped; max edge; zero base
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
		send_hit(17'sh10000, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_hit(17'sh0FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		set_regs(16'd46080, 16'd1, 16'd25600, 16'd1);
		send_hit(17'sd46080, 16'h0010, 1'b1, 1'b1, 1'b0);
		send_hit(-17'sd46080, 16'h0010, 1'b1, 1'b1, 1'b1);

		// random, several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(16'd10752, 16'd5376, 16'd768, 16'd100);
				1: set_regs(16'd0, 16'd25600, 16'd1, 16'hFFFF);
				2: set_regs(16'd46080, 16'd1, 16'd25600, 16'd0);
				3: set_regs(16'($urandom_range(0, 46080)), 16'($urandom_range(1, 25600)),
					16'($urandom_range(1, 25600)), 16'($urandom()));
				4: set_regs(16'hFFFF, 16'd0, 16'd0, 16'd1);
				default: set_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()));
			endcase
			for (int e = 0; e < 12; e++)
				rand_event(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 16));
		end

		// event long enough to saturate both sums, on the edge so weight is one
		set_regs(16'd10752, 16'd5376, 16'd768, 16'hFFFF);
		for (int i = 0; i < 1100; i++)
			send_hit(17'sd10752, 16'hFFFF, 1'b1, 1'b1, i == 1099);

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[cone_charge_score] OK");
		else
			$display("[cone_charge_score] ERROR");
		$finish;
	end
endmodule

// File: sim.f
design/ccs_pkg.sv
design/ccs_datapath.sv
design/ccs_ctrl.sv
design/cone_charge_score.sv
design/ccs_checker.sv
verif/ccs_checker.sv
verif/testbench.sv
